### rtl/rsas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsas_pkg
// Shared constants and types for the rotated sorted array search block.
// ----------------------------------------------------------------------------
package rsas_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = ADDR_W + 1;   // holds 0..DEPTH
  localparam int DATA_W = 32;
  localparam int LEN_W  = 11;
  localparam int IDX_W  = 10;
  localparam int POS_W  = 10;

  typedef enum logic [0:0] {
    KIND_LOAD   = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_MID,
    S_LOW,
    S_LAST,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

endpackage

### rtl/rsas_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsas_store
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rsas_store (
  input  logic                                clk_i,
  input  rsas_pkg::store_req_t                req_i,
  output logic signed [rsas_pkg::DATA_W-1:0]  rdata_o
);

  logic [rsas_pkg::DATA_W-1:0] mem [rsas_pkg::DEPTH];
  logic [rsas_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = $signed(rdata_q);

endmodule

### rtl/rotated_sorted_array_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_sorted_array_search
// Binary search for a key over an ascending, possibly rotated array.
// ----------------------------------------------------------------------------
// A load request (kind 0) writes one entry while busy stays low. A search
// request (kind 1) raises busy until its result is shown on done_o for one
// cycle, which the receiver must take at once. Each halving step starts in
// S_PROBE with the bounds check, which also issues the probe read, and then
// has one state per element read from the store (S_MID for the probe,
// S_LOW for the low entry, and S_LAST for the last entry of a rotated half).
// A search that misses ends on a final bounds check after at most
// ceil(log2(length+1)) steps, with length capped at the 1024-entry depth. A
// probe that hits ends its step after the probe read and skips the final
// bounds check.
// Loads are taken only while idle.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [0:0]                             kind_i,
  input  logic [rsas_pkg::IDX_W-1:0]             entry_index_i,
  input  logic signed [rsas_pkg::DATA_W-1:0]     entry_value_i,
  input  logic signed [rsas_pkg::DATA_W-1:0]     search_key_i,
  input  logic                                   cfg_we_i,
  input  logic [rsas_pkg::LEN_W-1:0]             cfg_wdata_i,
  output logic                                   done_o,
  output logic                                   found_o,
  output logic [rsas_pkg::POS_W-1:0]             position_o
);

  rsas_pkg::state_e state_q, state_d;

  logic [rsas_pkg::LEN_W-1:0]          length_q;
  logic [rsas_pkg::CNT_W-1:0]          lo_q, hi_q, mid_q, mid_c, n_c;
  logic signed [rsas_pkg::DATA_W-1:0]  key_q, vmid_q, rdata;
  logic                                found_q;
  logic [rsas_pkg::POS_W-1:0]          pos_q;
  logic                                accept, key_hit, low_sorted;
  logic                                go_left_low, go_right_last;
  rsas_pkg::store_req_t                store_req;

  assign accept = start && !busy;

  // saturate length to the store depth
  assign n_c = (32'(length_q) > 32'(rsas_pkg::DEPTH)) ?
               rsas_pkg::CNT_W'(rsas_pkg::DEPTH) : rsas_pkg::CNT_W'(length_q);

  assign mid_c = lo_q + ((hi_q - lo_q) >> 1);

  assign key_hit       = (rdata == key_q);
  assign low_sorted    = (rdata <= vmid_q);
  assign go_left_low   = (rdata <= key_q) && (key_q < vmid_q);
  assign go_right_last = (vmid_q < key_q) && (key_q <= rdata);

  rsas_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rsas_pkg::S_IDLE: begin
        if (accept && kind_i == rsas_pkg::KIND_SEARCH) state_d = rsas_pkg::S_PROBE;
      end
      rsas_pkg::S_PROBE: begin
        state_d = (lo_q < hi_q) ? rsas_pkg::S_MID : rsas_pkg::S_DONE;
      end
      rsas_pkg::S_MID: begin
        state_d = key_hit ? rsas_pkg::S_DONE : rsas_pkg::S_LOW;
      end
      rsas_pkg::S_LOW: begin
        state_d = low_sorted ? rsas_pkg::S_PROBE : rsas_pkg::S_LAST;
      end
      rsas_pkg::S_LAST: begin
        state_d = rsas_pkg::S_PROBE;
      end
      rsas_pkg::S_DONE: begin
        state_d = rsas_pkg::S_IDLE;
      end
      default: begin
        state_d = rsas_pkg::S_IDLE;
      end
    endcase
  end

  // outputs and store port
  always_comb begin
    busy            = (state_q != rsas_pkg::S_IDLE);
    done_o          = (state_q == rsas_pkg::S_DONE);
    store_req.we    = 1'b0;
    store_req.waddr = rsas_pkg::ADDR_W'(32'(entry_index_i));
    store_req.wdata = entry_value_i;
    store_req.raddr = rsas_pkg::ADDR_W'(mid_c);
    case (state_q)
      rsas_pkg::S_IDLE: begin
        store_req.we = accept && (kind_i == rsas_pkg::KIND_LOAD) &&
                       (32'(entry_index_i) < 32'(rsas_pkg::DEPTH));
      end
      rsas_pkg::S_PROBE: begin
        store_req.raddr = rsas_pkg::ADDR_W'(mid_c);
      end
      rsas_pkg::S_MID: begin
        store_req.raddr = rsas_pkg::ADDR_W'(lo_q);
      end
      rsas_pkg::S_LOW: begin
        store_req.raddr = rsas_pkg::ADDR_W'(hi_q - rsas_pkg::CNT_W'(1));
      end
      default: begin
        store_req.we = 1'b0;
      end
    endcase
  end

  assign found_o    = found_q;
  assign position_o = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rsas_pkg::S_IDLE;
      length_q <= '0;
      found_q  <= 1'b0;
      pos_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) length_q <= cfg_wdata_i;
      if (state_q == rsas_pkg::S_IDLE && state_d == rsas_pkg::S_PROBE) begin
        found_q <= 1'b0;
        pos_q   <= '0;
      end else if (state_q == rsas_pkg::S_MID && key_hit) begin
        found_q <= 1'b1;
        pos_q   <= rsas_pkg::POS_W'(32'(mid_q));
      end
    end
  end

  // search datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      rsas_pkg::S_IDLE: begin
        if (accept) begin
          key_q <= search_key_i;
          lo_q  <= '0;
          hi_q  <= n_c;
        end
      end
      rsas_pkg::S_PROBE: begin
        mid_q <= mid_c;
      end
      rsas_pkg::S_MID: begin
        vmid_q <= rdata;
      end
      rsas_pkg::S_LOW: begin
        // rdata is the low element; a rotated half waits for the last one
        if (low_sorted) begin
          if (go_left_low) hi_q <= mid_q;
          else             lo_q <= mid_q + rsas_pkg::CNT_W'(1);
        end
      end
      rsas_pkg::S_LAST: begin
        if (go_right_last) lo_q <= mid_q + rsas_pkg::CNT_W'(1);
        else               hi_q <= mid_q;
      end
      default: begin
        key_q <= key_q;
      end
    endcase
  end

endmodule

### rtl/rsas_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsas_chk
// Port-level checks for the rotated sorted array search block.
// ----------------------------------------------------------------------------
module rsas_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic [0:0]                         kind_i,
  input logic                               done_o,
  input logic                               found_o,
  input logic [rsas_pkg::POS_W-1:0]         position_o
);

  // a result only ends a search that is still in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe while idle");

  // the block is free again right after a result
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o)) else $error("busy after result");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (position_o == '0)) else $error("miss with position");

  // a load request never occupies the block
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == rsas_pkg::KIND_LOAD) |=> (!busy && !done_o))
    else $error("load request made block busy");

  // a search request always occupies the block
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == rsas_pkg::KIND_SEARCH) |=> busy)
    else $error("search request not started");

endmodule

bind rotated_sorted_array_search rsas_chk u_rsas_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .kind_i     (kind_i),
  .done_o     (done_o),
  .found_o    (found_o),
  .position_o (position_o)
);

### verif/rsas_search_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsas_search_sb_pkg
// Scoreboard for the rotated sorted array search: keeps its own copy of the
// element store and the length register, works out the found flag and the
// position for every search request, and checks each result in order.
// ----------------------------------------------------------------------------
package rsas_search_sb_pkg;
  import rsas_pkg::*;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_outcome_t;

  class search_scoreboard;
    logic signed [DATA_W-1:0] entries [DEPTH];
    logic [LEN_W-1:0]         length_reg;
    search_outcome_t          search_results_q [$];
    int unsigned              errors;

    function new();
      length_reg = '0;
      errors     = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function void set_length(logic [LEN_W-1:0] len);
      length_reg = len;
    endfunction

    // half-open search, stops at the first probe equal to the key
    function search_outcome_t locate_key(logic signed [DATA_W-1:0] key);
      search_outcome_t          res;
      int unsigned              lo;
      int unsigned              hi;
      int unsigned              mid;
      logic signed [DATA_W-1:0] v_mid;
      logic signed [DATA_W-1:0] v_lo;
      logic signed [DATA_W-1:0] v_last;
      res = '0;
      lo  = 0;
      hi  = (length_reg > DEPTH) ? DEPTH : length_reg;
      while (lo < hi) begin
        mid   = lo + (hi - lo) / 2;
        v_mid = entries[mid];
        v_lo  = entries[lo];
        if (key == v_mid) begin
          res.found    = 1'b1;
          res.position = mid[POS_W-1:0];
          return res;
        end
        if (v_lo <= v_mid) begin
          // lower half is in order
          if (v_lo <= key && key < v_mid) hi = mid;
          else lo = mid + 1;
        end else begin
          v_last = entries[hi - 1];
          if (v_mid < key && key <= v_last) lo = mid + 1;
          else hi = mid;
        end
      end
      return res;
    endfunction

    function void note_request(kind_e kind, logic [IDX_W-1:0] idx,
                               logic signed [DATA_W-1:0] value,
                               logic signed [DATA_W-1:0] key);
      if (kind == KIND_LOAD) begin
        if (idx < DEPTH) entries[idx] = value;
      end else begin
        search_results_q.push_back(locate_key(key));
      end
    endfunction

    function void check_result(logic found, logic [POS_W-1:0] position);
      search_outcome_t want;
      if (search_results_q.size() == 0) begin
        $display("%0t: result with no search pending: found %0b position %0d",
                 $time, found, position);
        errors++;
        return;
      end
      want = search_results_q.pop_front();
      if (found !== want.found) begin
        $display("%0t: found mismatch: expected %0b, actual %0b",
                 $time, want.found, found);
        errors++;
      end
      if (position !== want.position) begin
        $display("%0t: position mismatch: expected %0d, actual %0d",
                 $time, want.position, position);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return search_results_q.size();
    endfunction
  endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for rotated_sorted_array_search. Loads ascending arrays (rotated,
// with duplicates, or unordered) into the store, sets the length register
// and fires search requests with keys taken mostly from the array; every
// result is checked against the scoreboard's own search of the same data.
// ----------------------------------------------------------------------------
module tb_top;
  import rsas_pkg::*;
  import rsas_search_sb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned DRAIN       = 64;

  localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef enum int {
    SHAPE_SPREAD,
    SHAPE_DUPS,
    SHAPE_NOISE
  } shape_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [0:0]               kind_i;
  logic [IDX_W-1:0]         entry_index_i;
  logic signed [DATA_W-1:0] entry_value_i;
  logic signed [DATA_W-1:0] search_key_i;
  logic                     cfg_we_i;
  logic [LEN_W-1:0]         cfg_wdata_i;
  logic                     done_o;
  logic                     found_o;
  logic [POS_W-1:0]         position_o;

  search_scoreboard sb;
  bit               idle_on;
  int unsigned      items  = 0;
  int unsigned      cycles = 0;

  rotated_sorted_array_search DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .search_key_i  (search_key_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .found_o       (found_o),
    .position_o    (position_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[rotated_sorted_array_search] ERROR");
      $finish;
    end else if (rst_ni && done_o) begin
      sb.check_result(found_o, position_o);
    end
  end

  // start stays high after acceptance so back-to-back requests need no toggle
  task automatic send(kind_e kind, logic [IDX_W-1:0] idx,
                      logic signed [DATA_W-1:0] value,
                      logic signed [DATA_W-1:0] key);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    start         <= 1'b1;
    kind_i        <= kind;
    entry_index_i <= idx;
    entry_value_i <= value;
    search_key_i  <= key;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(kind, idx, value, key);
    items++;
  endtask

  task automatic load(logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] value);
    send(KIND_LOAD, idx, value, $urandom);
  endtask

  task automatic search(logic signed [DATA_W-1:0] key);
    send(KIND_SEARCH, IDX_W'($urandom), $urandom, key);
  endtask

  task automatic set_length(logic [LEN_W-1:0] len);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_length(len);
  endtask

  // writes entries 0..n-1 so that no search reads an unwritten entry
  task automatic fill_array(int unsigned n, shape_e shape);
    int          vals [$];
    int unsigned shift;
    for (int unsigned i = 0; i < n; i++) begin
      if (shape == SHAPE_DUPS) vals.push_back(int'($urandom_range(0, 6)) - 3);
      else vals.push_back($urandom);
    end
    if (shape != SHAPE_NOISE) vals.sort();
    shift = (n == 0) ? 0 : $urandom_range(0, n - 1);
    for (int unsigned i = 0; i < n; i++) begin
      load(i[IDX_W-1:0], vals[(i + shift) % n]);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_key(int unsigned n);
    logic signed [DATA_W-1:0] k;
    int unsigned              roll;
    roll = $urandom_range(0, 19);
    if (roll == 16) return KEY_MIN;
    if (roll == 17) return KEY_MAX;
    if (n == 0 || roll >= 18) return $urandom;
    k = sb.entries[$urandom_range(0, n - 1)];
    // neighbors of stored values probe the miss paths
    if (roll >= 14) return k - 1;
    if (roll >= 12) return k + 1;
    return k;
  endfunction

  task automatic search_burst(int unsigned count, int unsigned n);
    repeat (count) search(pick_key(n));
  endtask

  initial begin
    int unsigned stop_at;
    int unsigned len;
    shape_e      shape;
    sb            = new();
    rst_ni        = 1'b0;
    start         = 1'b0;
    kind_i        = KIND_LOAD;
    entry_index_i = '0;
    entry_value_i = '0;
    search_key_i  = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    idle_on       = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty array: length is zero out of reset
    search(KEY_MIN);
    search(KEY_MAX);
    search($urandom);

    // rotated array that wraps from the largest value to the smallest
    set_length(LEN_W'(8));
    load(0, 5);
    load(1, 100);
    load(2, KEY_MAX);
    load(3, KEY_MIN);
    load(4, -7);
    load(5, -1);
    load(6, 0);
    load(7, 3);
    search(KEY_MIN);
    search(KEY_MAX);
    search(0);
    search(4);
    search(101);
    search(5);
    search(3);

    // whole store in use, then lengths past the store size
    set_length(LEN_W'(DEPTH));
    fill_array(DEPTH, SHAPE_SPREAD);
    search_burst(30, DEPTH);
    set_length('1);
    search_burst(10, DEPTH);
    set_length(LEN_W'(1500));
    search_burst(6, DEPTH);

    stop_at = items + 400;
    while (items < stop_at) begin
      idle_on = (items + 80 < stop_at) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = 1;
        2:       len = 2;
        9:       len = $urandom_range(41, 100);
        default: len = $urandom_range(3, 40);
      endcase
      case ($urandom_range(0, 5))
        0, 1:    shape = SHAPE_DUPS;
        2:       shape = SHAPE_NOISE;
        default: shape = SHAPE_SPREAD;
      endcase
      set_length(len[LEN_W-1:0]);
      fill_array(len, shape);
      search_burst($urandom_range(6, 20), len);
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[rotated_sorted_array_search] OK");
    end else begin
      $display("[rotated_sorted_array_search] ERROR");
    end
    $finish;
  end

endmodule
